@@ rtl/pcbs_pkg.sv @@
package pcbs_pkg;

  localparam int MaxAxes = 256;
  localparam int AxisW   = $clog2(MaxAxes);
  localparam int ValueW  = 16;

  typedef enum logic [1:0] {
    CFG_BOX_X_MIN = 2'd0,
    CFG_BOX_X_MAX = 2'd1,
    CFG_BOX_Y_MIN = 2'd2,
    CFG_BOX_Y_MAX = 2'd3
  } cfg_idx_t;

endpackage

@@ rtl/parallel_coords_box_select.sv @@
// Parallel-coordinates box selection. Each transaction on the s_axis side carries
// one plotted value of a row, axis 0 first; tlast marks the row's final axis.
// The segment between consecutive axes i and i+1 is tested against the box when
// i lies in floor(box_x_min)..floor(box_x_max); at the end of a row one
// transaction on m_axis reports whether any tested segment crossed the box and
// the row was in the input selection. Values past axis MAX_AXES-1 are ignored,
// but their tlast still ends the row. Throughput is one value per clock, but a
// row end stalls while an unaccepted result holds the output register. A value
// is registered, tested combinationally by two 17x10 multiplies and sign checks,
// and the row result lands in an output register. The user writes box registers
// over the cfg channel only while no row is in flight; the block does not check.
module parallel_coords_box_select (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] value
  input  logic [0:0]  s_axis_tuser,   // [0] in_selection
  input  logic        s_axis_tlast,   // last_in_row
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] row_hit, [7:1] zero
);

  localparam logic [pcbs_pkg::AxisW-1:0] LastAxis =
    pcbs_pkg::AxisW'(pcbs_pkg::MaxAxes - 1);

  // box registers
  logic [15:0] box_x_min, box_x_max, box_y_min, box_y_max;

  // input stage
  logic        s1_valid;
  logic [15:0] s1_value;
  logic        s1_sel;
  logic        s1_last;
  logic        s1_adv;

  // row state
  logic [15:0]                 previous_value;
  logic [pcbs_pkg::AxisW-1:0]  axis_position;
  logic                        row_hit_so_far;
  logic                        row_full;

  // output register
  logic out_valid;
  logic out_hit;

  // segment test
  logic [pcbs_pkg::AxisW-1:0] seg;
  logic [7:0]                 seg8;
  logic                       in_range;
  logic signed [16:0]         dl_raw, dr_raw;
  logic signed [9:0]          dl, dr;
  logic signed [16:0]         dy, ymin_d, ymax_d;
  logic signed [26:0]         prod_l, prod_r;
  logic signed [27:0]         ymin_s, ymax_s;
  logic signed [27:0]         ta, tb, tc, td;
  logic                       pair_ab, pair_cd;
  logic                       seg_hit;
  logic                       row_hit_now;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_x_min <= '0;
      box_x_max <= '0;
      box_y_min <= '0;
      box_y_max <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pcbs_pkg::cfg_idx_t'(cfg_index))
        pcbs_pkg::CFG_BOX_X_MIN: box_x_min <= cfg_data;
        pcbs_pkg::CFG_BOX_X_MAX: box_x_max <= cfg_data;
        pcbs_pkg::CFG_BOX_Y_MIN: box_y_min <= cfg_data;
        pcbs_pkg::CFG_BOX_Y_MAX: box_y_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // only a row end needs the output slot
  assign s1_adv        = s1_valid && (!s1_last || !out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_value <= s_axis_tdata;
      s1_sel   <= s_axis_tuser[0];
      s1_last  <= s_axis_tlast;
    end
  end

  always_comb begin
    seg      = axis_position - 1'b1;
    seg8     = 8'(seg);
    in_range = (seg8 >= box_x_min[15:8]) && (seg8 <= box_x_max[15:8]);

    // offsets from axis seg in Q8.8, clipped to the segment span
    dl_raw = $signed({1'b0, box_x_min}) - $signed({1'b0, seg8, 8'h00});
    dr_raw = $signed({1'b0, box_x_max}) - $signed({1'b0, seg8, 8'h00});
    dl = dl_raw[16] ? 10'sd0 : $signed({1'b0, dl_raw[8:0]});
    dr = (dr_raw > 17'sd256) ? 10'sd256 : $signed({1'b0, dr_raw[8:0]});

    dy     = $signed({1'b0, s1_value})  - $signed({1'b0, previous_value});
    ymin_d = $signed({1'b0, box_y_min}) - $signed({1'b0, previous_value});
    ymax_d = $signed({1'b0, box_y_max}) - $signed({1'b0, previous_value});

    prod_l = dy * dl;
    prod_r = dy * dr;

    ymin_s = $signed({{3{ymin_d[16]}}, ymin_d, 8'h00});
    ymax_s = $signed({{3{ymax_d[16]}}, ymax_d, 8'h00});

    ta = ymax_s - 28'(prod_r);
    tb = ymin_s - 28'(prod_l);
    tc = ymin_s - 28'(prod_r);
    td = ymax_s - 28'(prod_l);

    // zero or opposite signs
    pair_ab = (ta == '0) || (tb == '0) || (ta[27] ^ tb[27]);
    pair_cd = (tc == '0) || (td == '0) || (tc[27] ^ td[27]);

    seg_hit     = !row_full && (axis_position != '0) && in_range && (pair_ab || pair_cd);
    row_hit_now = (row_hit_so_far || seg_hit) && s1_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_value <= '0;
      axis_position  <= '0;
      row_hit_so_far <= 1'b0;
      row_full       <= 1'b0;
    end else if (s1_adv) begin
      if (!row_full) begin
        previous_value <= s1_value;
      end
      if (s1_last) begin
        axis_position  <= '0;
        row_hit_so_far <= 1'b0;
        row_full       <= 1'b0;
      end else if (!row_full) begin
        if (seg_hit) begin
          row_hit_so_far <= 1'b1;
        end
        if (axis_position == LastAxis) begin
          row_full <= 1'b1;
        end else begin
          axis_position <= axis_position + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      out_hit <= row_hit_now;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_hit};

  a_full_at_last_axis: assert property (@(posedge clk) disable iff (rst)
    row_full |-> axis_position == LastAxis)
    else $error("row_full set away from last axis");

  a_row_end_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_last) |=> (axis_position == '0 && !row_hit_so_far && !row_full))
    else $error("row state not cleared after row end");

  a_row_end_emits: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_last) |=> m_axis_tvalid)
    else $error("row end produced no result");

  a_unselected_no_hit: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_last && !s1_sel) |=> !m_axis_tdata[0])
    else $error("unselected row reported a hit");

endmodule
